// ===== rtl/mse_pkg.sv =====
package mse_pkg;

  // Opcode and function codes
  localparam logic [31:0] HALT_WORD = 32'hffff_ffff;
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_JAL   = 6'h03;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_BNE   = 6'h05;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_SLTI  = 6'h0a;
  localparam logic [5:0] OPC_ANDI  = 6'h0c;
  localparam logic [5:0] OPC_ORI   = 6'h0d;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2b;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_JR  = 6'h08;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2a;

  localparam logic [4:0]  LINK_REG  = 5'd31;
  localparam logic [31:0] PC_RESET  = 32'h0000_1000;
  localparam logic [31:0] PC_REGION = 32'hf000_0000;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR, OP_SLT, OP_SLL, OP_SRL, OP_SRA, OP_JR,
    OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_LW, OP_SW, OP_BEQ, OP_BNE, OP_J, OP_JAL,
    OP_HALT, OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HALT = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Decoded instruction as it sits in the issue queue
  typedef struct packed {
    logic [31:0] instr;
    logic        adv;
    op_e         op;
    logic        wr;
    logic [4:0]  dst;
  } item_t;

  // Queue head seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Back end control toward the front end
  typedef struct packed {
    logic pop;
    logic busy;
  } ctl_t;

  // Register file contents after reset
  function automatic logic [31:0] reg_reset_val(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd16:   v = 32'h0000_0010;
      5'd17:   v = 32'h0000_1000;
      5'd18:   v = 32'h0000_0020;
      5'd19:   v = 32'h0000_0003;
      5'd20:   v = 32'hbada_cafe;
      5'd21:   v = 32'hcdcd_cdcd;
      5'd22:   v = 32'hffff_ffff;
      5'd23:   v = 32'h0000_0007;
      5'd29:   v = 32'h0000_8000;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Preset bytes at the bottom of data memory
  function automatic logic [7:0] preset_byte(input logic [5:0] addr);
    logic [7:0] v;
    unique case (addr)
      6'd0:  v = 8'h00; 6'd1:  v = 8'h11; 6'd2:  v = 8'h22; 6'd3:  v = 8'h33;
      6'd4:  v = 8'h44; 6'd5:  v = 8'h55; 6'd6:  v = 8'h66; 6'd7:  v = 8'h77;
      6'd8:  v = 8'hde; 6'd9:  v = 8'had; 6'd10: v = 8'hbe; 6'd11: v = 8'hef;
      6'd16: v = 8'h68; 6'd17: v = 8'h65; 6'd18: v = 8'h6c; 6'd19: v = 8'h6c;
      6'd20: v = 8'h6f; 6'd21: v = 8'h20; 6'd22: v = 8'h77; 6'd23: v = 8'h6f;
      6'd24: v = 8'h72; 6'd25: v = 8'h6c; 6'd26: v = 8'h64; 6'd27: v = 8'h21;
      6'd28: v = 8'h21;
      6'd32: v = 8'h61; 6'd33: v = 8'h77; 6'd34: v = 8'h65; 6'd35: v = 8'h73;
      6'd36: v = 8'h6f; 6'd37: v = 8'h6d; 6'd38: v = 8'h65; 6'd39: v = 8'h20;
      6'd40: v = 8'h63; 6'd41: v = 8'h6f; 6'd42: v = 8'h6d; 6'd43: v = 8'h70;
      6'd44: v = 8'h75; 6'd45: v = 8'h74; 6'd46: v = 8'h65; 6'd47: v = 8'h72;
      6'd48: v = 8'h20; 6'd49: v = 8'h61; 6'd50: v = 8'h72; 6'd51: v = 8'h63;
      6'd52: v = 8'h68; 6'd53: v = 8'h69; 6'd54: v = 8'h74; 6'd55: v = 8'h65;
      6'd56: v = 8'h63; 6'd57: v = 8'h74; 6'd58: v = 8'h75; 6'd59: v = 8'h72;
      6'd60: v = 8'h65; 6'd61: v = 8'h21;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mse_ram.sv =====
module mse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mse_front.sv =====
module mse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [31:0]   instr_word_i,
  input  logic          advance_pc_i,
  input  mse_pkg::ctl_t ctl_i,
  output mse_pkg::head_t head_o
);
  import mse_pkg::*;

  item_t       dec;
  op_e         dec_op;
  logic [5:0]  opc, fn;
  logic        writer;
  logic [4:0]  dst;

  item_t       ent_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  // Classify the instruction word
  always_comb begin
    opc    = instr_word_i[31:26];
    fn     = instr_word_i[5:0];
    dec_op = OP_BAD;
    if (instr_word_i == HALT_WORD) begin
      dec_op = OP_HALT;
    end else begin
      unique case (opc)
        OPC_RTYPE: begin
          unique case (fn)
            FN_ADD:  dec_op = OP_ADD;
            FN_SUB:  dec_op = OP_SUB;
            FN_AND:  dec_op = OP_AND;
            FN_OR:   dec_op = OP_OR;
            FN_NOR:  dec_op = OP_NOR;
            FN_SLT:  dec_op = OP_SLT;
            FN_SLL:  dec_op = OP_SLL;
            FN_SRL:  dec_op = OP_SRL;
            FN_SRA:  dec_op = OP_SRA;
            FN_JR:   dec_op = OP_JR;
            default: dec_op = OP_BAD;
          endcase
        end
        OPC_J:    dec_op = OP_J;
        OPC_JAL:  dec_op = OP_JAL;
        OPC_BEQ:  dec_op = OP_BEQ;
        OPC_BNE:  dec_op = OP_BNE;
        OPC_ADDI: dec_op = OP_ADDI;
        OPC_SLTI: dec_op = OP_SLTI;
        OPC_ANDI: dec_op = OP_ANDI;
        OPC_ORI:  dec_op = OP_ORI;
        OPC_LW:   dec_op = OP_LW;
        OPC_SW:   dec_op = OP_SW;
        default:  dec_op = OP_BAD;
      endcase
    end
  end

  // Destination register; writes to register zero are dropped here
  always_comb begin
    writer = 1'b0;
    dst    = instr_word_i[15:11];
    unique case (dec_op)
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR, OP_SLT, OP_SLL, OP_SRL, OP_SRA: begin
        writer = 1'b1;
        dst    = instr_word_i[15:11];
      end
      OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_LW: begin
        writer = 1'b1;
        dst    = instr_word_i[20:16];
      end
      OP_JAL: begin
        writer = 1'b1;
        dst    = LINK_REG;
      end
      default: writer = 1'b0;
    endcase
    dec.instr = instr_word_i;
    dec.adv   = advance_pc_i;
    dec.op    = dec_op;
    dec.wr    = writer && (dst != 5'd0);
    dec.dst   = dst;
  end

  // Two-entry issue queue
  assign ready_o = (cnt_q != 2'd2) && !ctl_i.busy;
  assign push    = valid_i && ready_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !ctl_i.pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && ctl_i.pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (ctl_i.pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= dec;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = ent_q[rptr_q];

endmodule

// ===== rtl/mse_back.sv =====
module mse_back #(
  parameter int MEM_BYTES = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mse_pkg::head_t head_i,
  output mse_pkg::ctl_t  ctl_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [1:0]     status_o,
  output logic [31:0]    next_pc_o,
  output logic           reg_we_o,
  output logic [4:0]     reg_index_o,
  output logic [31:0]    reg_value_o,
  output logic           mem_we_o,
  output logic [15:0]    mem_addr_o,
  output logic [31:0]    store_value_o
);
  import mse_pkg::*;

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = AW - 2;
  localparam logic [31:0] AMASK = 32'(MEM_BYTES - 1);

  logic en, pop;

  // Clearing pass over the data memory
  logic          clr_busy_q;
  logic [RW-1:0] clr_row_q;

  // Execute stage
  logic        b1_valid_q;
  item_t       b1_q;
  logic        rv_a_q, rv_b_q;
  logic [31:0] pc_q;

  // Memory stage
  logic        b2_valid_q, b2_wr_q, b2_lw_q, b2_mw_q;
  status_e     b2_status_q;
  logic [31:0] b2_pc_q, b2_val_q, b2_sval_q;
  logic [4:0]  b2_dst_q;
  logic [1:0]  b2_alo_q;
  logic [15:0] b2_maddr_q;
  logic [31:0] b2_val_fin;

  // Last committed register write
  logic        lw_valid_q;
  logic [4:0]  lw_dst_q;
  logic [31:0] lw_val_q;

  // Output register
  logic        out_valid_q, out_we_q, out_mw_q;
  status_e     out_status_q;
  logic [31:0] out_pc_q, out_val_q, out_sval_q;
  logic [4:0]  out_idx_q;
  logic [15:0] out_maddr_q;

  logic [31:0] regv_q;
  logic [31:0] rf_a, rf_b, a, b;
  logic        rf_we;
  logic [4:0]  rs, rt;

  assign en  = !out_valid_q || ready_i;
  assign pop = en && head_i.valid && !clr_busy_q;
  assign ctl_o.pop  = pop;
  assign ctl_o.busy = clr_busy_q;

  // Register file: two copies for two read ports
  assign rf_we = en && b2_valid_q && b2_wr_q;

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (b2_dst_q),
    .wdata_i (b2_val_fin),
    .re_i    (pop),
    .raddr_i (head_i.item.instr[25:21]),
    .rdata_o (rf_a)
  );

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (b2_dst_q),
    .wdata_i (b2_val_fin),
    .re_i    (pop),
    .raddr_i (head_i.item.instr[20:16]),
    .rdata_o (rf_b)
  );

  // Operand read with reset values and forwarding
  always_comb begin
    rs = b1_q.instr[25:21];
    rt = b1_q.instr[20:16];
    if (b2_valid_q && b2_wr_q && b2_dst_q == rs) begin
      a = b2_val_fin;
    end else if (lw_valid_q && lw_dst_q == rs) begin
      a = lw_val_q;
    end else begin
      a = rv_a_q ? rf_a : reg_reset_val(rs);
    end
    if (b2_valid_q && b2_wr_q && b2_dst_q == rt) begin
      b = b2_val_fin;
    end else if (lw_valid_q && lw_dst_q == rt) begin
      b = lw_val_q;
    end else begin
      b = rv_b_q ? rf_b : reg_reset_val(rt);
    end
  end

  // Execute
  logic [31:0] se, pc_base, pc_new, val, ea;
  logic [4:0]  sh;
  logic        is_lw, is_sw;
  status_e     status;

  always_comb begin
    sh      = b1_q.instr[10:6];
    se      = {{16{b1_q.instr[15]}}, b1_q.instr[15:0]};
    pc_base = pc_q + (b1_q.adv ? 32'd4 : 32'd0);
    pc_new  = pc_base;
    ea      = a + se;
    val     = 32'd0;
    is_lw   = 1'b0;
    is_sw   = 1'b0;
    status  = ST_OK;
    unique case (b1_q.op)
      OP_ADD:  val = a + b;
      OP_SUB:  val = a - b;
      OP_AND:  val = a & b;
      OP_OR:   val = a | b;
      OP_NOR:  val = ~(a | b);
      OP_SLT:  val = {31'd0, $signed(a) < $signed(b)};
      OP_SLL:  val = b << sh;
      OP_SRL:  val = b >> sh;
      OP_SRA:  val = $unsigned($signed(b) >>> sh);
      OP_JR:   pc_new = a;
      OP_ADDI: val = ea;
      OP_ANDI: val = a & {16'd0, b1_q.instr[15:0]};
      OP_ORI:  val = a | {16'd0, b1_q.instr[15:0]};
      OP_SLTI: val = {31'd0, $signed(a) < $signed(se)};
      OP_LW:   is_lw = 1'b1;
      OP_SW:   is_sw = 1'b1;
      OP_BEQ: begin
        if (a == b) begin
          pc_new = pc_base + {se[29:0], 2'b00};
        end
      end
      OP_BNE: begin
        if (a != b) begin
          pc_new = pc_base + {se[29:0], 2'b00};
        end
      end
      OP_J:    pc_new = (pc_base & PC_REGION) | {4'd0, b1_q.instr[25:0], 2'b00};
      OP_JAL: begin
        val    = pc_base;
        pc_new = (pc_base & PC_REGION) | {4'd0, b1_q.instr[25:0], 2'b00};
      end
      OP_HALT: status = ST_HALT;
      default: status = ST_BAD;
    endcase
  end

  // Byte banks, big-endian word spread over four banks
  logic [AW-1:0] a_w;
  logic [7:0]    bank_rd [4];

  assign a_w = ea[AW-1:0];

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0]    k;
    logic [AW-1:0] baddr;
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;

    assign k     = 2'(j) - a_w[1:0];
    assign baddr = a_w + AW'(k);

    always_comb begin
      if (clr_busy_q) begin
        we    = 1'b1;
        waddr = clr_row_q;
        wdata = (clr_row_q < RW'(16)) ? preset_byte({clr_row_q[3:0], 2'(j)}) : 8'h00;
      end else begin
        we    = en && b1_valid_q && is_sw;
        waddr = baddr[AW-1:2];
        wdata = b[8 * (2'd3 - k) +: 8];
      end
    end

    mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (en && b1_valid_q && is_lw),
      .raddr_i (baddr[AW-1:2]),
      .rdata_o (bank_rd[j])
    );
  end

  // Load word assembly
  assign b2_val_fin = b2_lw_q ? {bank_rd[b2_alo_q], bank_rd[b2_alo_q + 2'd1],
                                 bank_rd[b2_alo_q + 2'd2], bank_rd[b2_alo_q + 2'd3]}
                              : b2_val_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_row_q   <= '0;
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lw_valid_q  <= 1'b0;
      regv_q      <= '0;
      pc_q        <= PC_RESET;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + RW'(1);
        if (clr_row_q == RW'(ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (en) begin
        b1_valid_q  <= pop;
        b2_valid_q  <= b1_valid_q;
        out_valid_q <= b2_valid_q;
        if (b1_valid_q) begin
          pc_q <= pc_new;
        end
        if (rf_we) begin
          lw_valid_q       <= 1'b1;
          regv_q[b2_dst_q] <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_q   <= head_i.item;
      rv_a_q <= regv_q[head_i.item.instr[25:21]];
      rv_b_q <= regv_q[head_i.item.instr[20:16]];
    end
    if (en) begin
      b2_status_q <= status;
      b2_pc_q     <= pc_new;
      b2_wr_q     <= b1_q.wr;
      b2_dst_q    <= b1_q.dst;
      b2_val_q    <= val;
      b2_lw_q     <= is_lw;
      b2_mw_q     <= is_sw;
      b2_alo_q    <= a_w[1:0];
      b2_maddr_q  <= (is_lw || is_sw) ? 16'(ea & AMASK) : 16'd0;
      b2_sval_q   <= is_sw ? b : 32'd0;
      if (rf_we) begin
        lw_dst_q <= b2_dst_q;
        lw_val_q <= b2_val_fin;
      end
      out_status_q <= b2_status_q;
      out_pc_q     <= b2_pc_q;
      out_we_q     <= b2_wr_q;
      out_idx_q    <= b2_wr_q ? b2_dst_q : 5'd0;
      out_val_q    <= b2_wr_q ? b2_val_fin : 32'd0;
      out_mw_q     <= b2_mw_q;
      out_maddr_q  <= b2_maddr_q;
      out_sval_q   <= b2_sval_q;
    end
  end

  assign valid_o       = out_valid_q;
  assign status_o      = out_status_q;
  assign next_pc_o     = out_pc_q;
  assign reg_we_o      = out_we_q;
  assign reg_index_o   = out_idx_q;
  assign reg_value_o   = out_val_q;
  assign mem_we_o      = out_mw_q;
  assign mem_addr_o    = out_maddr_q;
  assign store_value_o = out_sval_q;

  // Nothing executes while memory is being cleared
  a_no_exec_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !b1_valid_q && !b2_valid_q)
    else $error("instruction in flight during clearing pass");

  // Register zero is never reported as written
  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_we_q |-> out_idx_q != 5'd0)
    else $error("write to register zero reported");

  // A store never also writes a register
  a_store_no_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mw_q |-> !out_we_q)
    else $error("store with register write");

  // Halt and unknown words leave registers and memory alone
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_OK |-> !out_we_q && !out_mw_q)
    else $error("halt or unknown word changed state");

endmodule

// ===== rtl/mips_subset_execute_unit.sv =====
// Executes one MIPS instruction word per transfer.
// Each instruction passes the queue, execute, memory and output registers in order.
// Throughput: one instruction per cycle through the byte-banked memory, if not stalled.
// Reset: registers and pc return to their preset values; a clearing pass over
// MEM_BYTES/4 rows (16384 by default) rewrites data memory, tready stays low meanwhile.
module mips_subset_execute_unit #(
  parameter int MEM_BYTES = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [39:0]  s_axis_tdata_i,   // instr_word[31:0], advance_pc[32], zero pad
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [119:0] m_axis_tdata_o,   // next_pc, reg_we, reg_index, reg_value,
                                         // mem_we, mem_addr, store_value, zero pad
  output logic [1:0]   m_axis_tuser_o    // status
);
  import mse_pkg::*;

  head_t       head;
  ctl_t        ctl;
  logic [31:0] next_pc, reg_value, store_value;
  logic        reg_we, mem_we;
  logic [4:0]  reg_index;
  logic [15:0] mem_addr;

  mse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid_i),
    .ready_o      (s_axis_tready_o),
    .instr_word_i (s_axis_tdata_i[31:0]),
    .advance_pc_i (s_axis_tdata_i[32]),
    .ctl_i        (ctl),
    .head_o       (head)
  );

  mse_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .ctl_o         (ctl),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .status_o      (m_axis_tuser_o),
    .next_pc_o     (next_pc),
    .reg_we_o      (reg_we),
    .reg_index_o   (reg_index),
    .reg_value_o   (reg_value),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .store_value_o (store_value)
  );

  assign m_axis_tdata_o = {1'b0, store_value, mem_addr, mem_we, reg_value, reg_index,
                           reg_we, next_pc};

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import mse_pkg::*;

  localparam int MEM_SIZE = 65536;
  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct packed {
    status_e     status;
    logic [31:0] next_pc;
    logic        reg_we;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [31:0] store_value;
  } outcome_t;

  // Shadow of the core: registers, pc, memory, and the queue of expected outcomes
  class exec_scoreboard;
    logic [31:0] regs[32];
    logic [31:0] pc;
    logic [7:0]  mem[MEM_SIZE];
    outcome_t    pending[$];
    int          errors;
    int          checked;

    function void clear();
      for (int i = 0; i < 32; i++) regs[i] = reg_reset_val(i[4:0]);
      pc = PC_RESET;
      for (int i = 0; i < MEM_SIZE; i++) mem[i] = (i < 64) ? preset_byte(i[5:0]) : 8'h00;
      pending.delete();
    endfunction

    function logic [31:0] rd(logic [4:0] idx);
      return idx == 5'd0 ? 32'h0 : regs[idx];
    endfunction

    // Execute one instruction word and queue the outcome
    function void note_instr(logic [31:0] w, logic adv);
      outcome_t   o;
      logic [5:0] opc, fn;
      logic [4:0] rs, rt, rd_i, sh;
      logic [31:0] a, b, simm, ea, val;
      logic        wr;
      logic [4:0]  dst;
      opc = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd_i = w[15:11];
      sh = w[10:6]; fn = w[5:0];
      a = rd(rs); b = rd(rt);
      simm = {{16{w[15]}}, w[15:0]};
      o = '0; o.status = ST_OK; wr = 1'b0; dst = 5'd0; val = 32'h0;
      if (adv) pc = pc + 32'd4;
      if (w == HALT_WORD) begin
        o.status = ST_HALT;
      end else if (opc == OPC_RTYPE) begin
        wr = 1'b1; dst = rd_i;
        case (fn)
          FN_ADD: val = a + b;
          FN_SUB: val = a - b;
          FN_AND: val = a & b;
          FN_OR:  val = a | b;
          FN_NOR: val = ~(a | b);
          FN_SLT: val = {31'b0, $signed(a) < $signed(b)};
          FN_SLL: val = b << sh;
          FN_SRL: val = b >> sh;
          FN_SRA: val = $signed(b) >>> sh;
          FN_JR: begin
            wr = 1'b0; pc = a;
          end
          default: begin
            wr = 1'b0; o.status = ST_BAD;
          end
        endcase
      end else if (opc == OPC_J || opc == OPC_JAL) begin
        if (opc == OPC_JAL) begin
          wr = 1'b1; dst = LINK_REG; val = pc;
        end
        pc = (pc & PC_REGION) | {4'b0, w[25:0], 2'b00};
      end else begin
        case (opc)
          OPC_ADDI: begin wr = 1'b1; dst = rt; val = a + simm; end
          OPC_ANDI: begin wr = 1'b1; dst = rt; val = a & {16'h0, w[15:0]}; end
          OPC_ORI:  begin wr = 1'b1; dst = rt; val = a | {16'h0, w[15:0]}; end
          OPC_SLTI: begin wr = 1'b1; dst = rt; val = {31'b0, $signed(a) < $signed(simm)}; end
          OPC_LW: begin
            ea = a + simm;
            o.mem_addr = ea[15:0];
            for (int k = 0; k < 4; k++) val = {val[23:0], mem[16'(ea + k)]};
            wr = 1'b1; dst = rt;
          end
          OPC_SW: begin
            ea = a + simm;
            o.mem_addr = ea[15:0];
            for (int k = 0; k < 4; k++) mem[16'(ea + k)] = b[31 - 8*k -: 8];
            o.mem_we = 1'b1; o.store_value = b;
          end
          OPC_BEQ: if (a == b) pc = pc + (simm << 2);
          OPC_BNE: if (a != b) pc = pc + (simm << 2);
          default: o.status = ST_BAD;
        endcase
      end
      if (wr && dst != 5'd0) begin
        regs[dst] = val;
        o.reg_we = 1'b1; o.reg_index = dst; o.reg_value = val;
      end
      o.next_pc = pc;
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected result", 0, got.next_pc);
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status) report("status", e.status, got.status);
      if (got.next_pc != e.next_pc) report("next_pc", e.next_pc, got.next_pc);
      if (got.reg_we != e.reg_we) report("reg_we", e.reg_we, got.reg_we);
      if (got.reg_index != e.reg_index) report("reg_index", e.reg_index, got.reg_index);
      if (got.reg_value != e.reg_value) report("reg_value", e.reg_value, got.reg_value);
      if (got.mem_we != e.mem_we) report("mem_we", e.mem_we, got.mem_we);
      if (got.mem_addr != e.mem_addr) report("mem_addr", e.mem_addr, got.mem_addr);
      if (got.store_value != e.store_value)
        report("store_value", e.store_value, got.store_value);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (errors <= 30)
        $display("mismatch #%0d on result %0d: %s expected %h got %h",
                 errors, checked, what, exp_v, got_v);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [39:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [119:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  mips_subset_execute_unit dut (.*);

  exec_scoreboard sb;
  int send_idle_pct = 13;
  int recv_idle_pct = 45;
  bit hold_off = 1'b0;
  int sent = 0;
  int quiet_cycles = 0;
  outcome_t got;
  bit in_xfer, out_xfer;

  initial forever #4 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor input and output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
      out_xfer = m_axis_tvalid_o && m_axis_tready_i;
      if (in_xfer) begin
        sb.note_instr(s_axis_tdata_i[31:0], s_axis_tdata_i[32]);
      end
      if (out_xfer) begin
        got.status      = status_e'(m_axis_tuser_o);
        got.next_pc     = m_axis_tdata_o[31:0];
        got.reg_we      = m_axis_tdata_o[32];
        got.reg_index   = m_axis_tdata_o[37:33];
        got.reg_value   = m_axis_tdata_o[69:38];
        got.mem_we      = m_axis_tdata_o[70];
        got.mem_addr    = m_axis_tdata_o[86:71];
        got.store_value = m_axis_tdata_o[118:87];
        sb.check_result(got);
      end
      if (in_xfer || out_xfer) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one instruction and wait for its transfer; starts and ends at a falling edge
  task automatic send_instr(logic [31:0] w, logic adv);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'b0, adv, w};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [4:0] pick_reg();
    return $urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(16, 23));
  endfunction

  // Random instruction biased toward valid encodings
  function automatic logic [31:0] rand_instr();
    logic [5:0] fns[10] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_NOR, FN_SLT,
                            FN_SLL, FN_SRL, FN_SRA, FN_JR};
    logic [5:0] ops[10] = '{OPC_ADDI, OPC_ANDI, OPC_ORI, OPC_SLTI, OPC_LW, OPC_SW,
                            OPC_BEQ, OPC_BNE, OPC_J, OPC_JAL};
    logic [31:0] w;
    int sel;
    sel = $urandom_range(99);
    w = $urandom;
    if (sel < 4) return HALT_WORD;
    if (sel < 10) return w;
    if (sel < 45) begin
      w[31:26] = OPC_RTYPE; w[25:21] = pick_reg(); w[20:16] = pick_reg();
      if (fns[sel % 10] == FN_JR && $urandom_range(1)) w[25:21] = 5'd17;
      w[5:0] = fns[$urandom_range(9)];
      if (w[5:0] == FN_JR && $urandom_range(3) != 0) w[25:21] = 5'd17;
      return w;
    end
    w[31:26] = ops[$urandom_range(9)];
    w[25:21] = pick_reg(); w[20:16] = pick_reg();
    if ((w[31:26] == OPC_LW || w[31:26] == OPC_SW) && $urandom_range(1))
      w[15:0] = 16'($urandom_range(0, 80));
    return w;
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] directed[$];
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every operation, register zero, overflow, wrap, halt, unknown
    directed = '{
      {OPC_RTYPE, 5'd20, 5'd22, 5'd8, 5'd0, FN_ADD},
      {OPC_RTYPE, 5'd16, 5'd20, 5'd9, 5'd0, FN_SUB},
      {OPC_RTYPE, 5'd20, 5'd21, 5'd10, 5'd0, FN_AND},
      {OPC_RTYPE, 5'd20, 5'd21, 5'd11, 5'd0, FN_OR},
      {OPC_RTYPE, 5'd0, 5'd0, 5'd12, 5'd0, FN_NOR},
      {OPC_RTYPE, 5'd22, 5'd16, 5'd13, 5'd0, FN_SLT},
      {OPC_RTYPE, 5'd0, 5'd20, 5'd14, 5'd31, FN_SLL},
      {OPC_RTYPE, 5'd0, 5'd20, 5'd15, 5'd31, FN_SRL},
      {OPC_RTYPE, 5'd0, 5'd20, 5'd24, 5'd4, FN_SRA},
      {OPC_RTYPE, 5'd0, 5'd20, 5'd25, 5'd0, FN_SRA},
      {OPC_RTYPE, 5'd16, 5'd16, 5'd0, 5'd0, FN_ADD},
      {OPC_RTYPE, 5'd0, 5'd0, 5'd0, 5'd0, 6'h3f},
      {OPC_ADDI, 5'd22, 5'd26, 16'h8000},
      {OPC_ANDI, 5'd22, 5'd27, 16'hffff},
      {OPC_ORI, 5'd0, 5'd28, 16'hffff},
      {OPC_SLTI, 5'd16, 5'd30, 16'hffff},
      {OPC_LW, 5'd0, 5'd1, 16'h0008},
      {OPC_LW, 5'd0, 5'd0, 16'hfffe},
      {OPC_SW, 5'd29, 5'd20, 16'h7ffe},
      {OPC_LW, 5'd0, 5'd2, 16'hfffe},
      {OPC_BEQ, 5'd16, 5'd16, 16'hfff0},
      {OPC_BNE, 5'd16, 5'd17, 16'h7fff},
      {OPC_JAL, 26'h3ffffff},
      {OPC_J, 26'h0000400},
      {OPC_RTYPE, 5'd17, 5'd0, 5'd0, 5'd0, FN_JR},
      {6'h3f, 26'h0},
      HALT_WORD
    };
    foreach (directed[i]) send_instr(directed[i], 1'(i % 2));

    // Random phases with rotating stall profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 13 : 0;
      for (int n = 0; n < 430; n++) begin
        if (ph == 2 && n == 100) begin
          // Long receiver hold-off while the sender keeps going
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        if (ph == 1 && n % 200 == 0) send_instr(HALT_WORD, 1'b0);
        send_instr(rand_instr(), 1'($urandom));
      end
    end
    s_axis_tvalid_i <= 1'b0;

    wait_drained();
    $display("ran %0d instructions, %0d results checked, all opcodes and stall profiles",
             sent, sb.checked);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== mips_subset_execute_unit.f =====
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_front.sv
rtl/mse_back.sv
rtl/mips_subset_execute_unit.sv
tb/sv/testbench.sv
